@@ rtl/core/lpsa_pkg.sv @@
// lpsa_pkg: shared types, codes and constants of the linear probe slot assigner
// used by lpsa_ctrl, lpsa_dpath and linear_probe_slot_assigner_unit
package lpsa_pkg;

   localparam int SLOTS_DEFAULT = 1024;
   localparam int CSR_W         = 11;
   localparam int RND_W         = 16;
   localparam int RND_CNT_W     = 4;
   localparam int CASE_W        = 31;
   localparam int SLOT_OUT_W    = 10;

   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;

   localparam logic [7:0] CHAR_C    = 8'h63;
   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [7:0] CHAR_UP_A = 8'h41;
   localparam logic [7:0] CHAR_UP_Z = 8'h5A;
   localparam logic [7:0] CASE_BIT  = 8'h20;

   localparam logic [1:0] OUT_CLOSED   = 2'd0;
   localparam logic [1:0] OUT_ASSIGNED = 2'd1;
   localparam logic [1:0] OUT_PENDING  = 2'd2;
   localparam logic [1:0] OUT_UNKNOWN  = 2'd3;

   typedef struct packed {
      logic [CASE_W-1:0] case_number;
      logic [7:0]        status_byte;
      logic [RND_W-1:0]  random_value;
   } req_type;

   typedef struct packed {
      logic [1:0]            outcome;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [CASE_W-1:0]     echoed_case;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       mem_read;
      logic       mem_write;
      logic       advance;
      logic       emit;
      logic [1:0] outcome;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clearing;
      logic is_close;
      logic is_open;
      logic has_room;
      logic div_last;
      logic slot_free;
      logic last_try;
      logic rsp_free;
   } status_type;

endpackage

@@ rtl/core/lpsa_ctrl.sv @@
// lpsa_ctrl: sequencer for classify, start-slot divide, probe and result hand-off
// depends on lpsa_pkg for the command, status and outcome codes
module lpsa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lpsa_pkg::status_type   status,
   output lpsa_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] outcome_ff, outcome_in;

   assign req_stall = status.clearing || (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      outcome_in = outcome_ff;
      cmd        = '0;
      cmd.outcome = outcome_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (status.is_close) begin
               outcome_in = lpsa_pkg::OUT_CLOSED;
               state_in   = ST_FINISH;
            end else if (status.is_open && status.has_room) begin
               state_in = ST_DIVIDE;
            end else if (status.is_open) begin
               outcome_in = lpsa_pkg::OUT_PENDING;
               state_in   = ST_FINISH;
            end else begin
               outcome_in = lpsa_pkg::OUT_UNKNOWN;
               state_in   = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (status.slot_free) begin
               cmd.mem_write = 1'b1;
               outcome_in    = lpsa_pkg::OUT_ASSIGNED;
               state_in      = ST_FINISH;
            end else if (status.last_try) begin
               outcome_in = lpsa_pkg::OUT_PENDING;
               state_in   = ST_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      outcome_ff <= outcome_in;
   end

endmodule

@@ rtl/core/lpsa_dpath.sv @@
// lpsa_dpath: slot table memory, clearing pass, start-slot remainder unit,
// probe index, counters and result register; depends on lpsa_pkg
module lpsa_dpath #(
   parameter int SLOTS = lpsa_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lpsa_pkg::req_type             req_payload,
   input  logic                          csr_write_enable,
   input  logic [lpsa_pkg::CSR_W-1:0]    csr_write_data,
   input  lpsa_pkg::cmd_type             cmd,
   output lpsa_pkg::status_type          status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lpsa_pkg::rsp_type             rsp_payload
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = (CW > lpsa_pkg::CSR_W) ? CW : lpsa_pkg::CSR_W;
   localparam logic [EW-1:0] SLOTS_EW  = EW'(SLOTS);
   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

   logic [lpsa_pkg::CASE_W-1:0] mem [SLOTS];

   logic [lpsa_pkg::CSR_W-1:0]     slots_cfg_ff, slots_cfg_in;
   lpsa_pkg::req_type              item_ff, item_in;
   logic [CW-1:0]                  eff_n_ff, eff_n_in;
   logic [CW-1:0]                  rem_ff, rem_in;
   logic [lpsa_pkg::RND_W-1:0]     div_ff, div_in;
   logic [lpsa_pkg::RND_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [IW-1:0]                  idx_ff, idx_in;
   logic [CW-1:0]                  tries_ff, tries_in;
   logic [lpsa_pkg::CSR_W-1:0]     assigned_ff, assigned_in;
   logic                           clearing_ff, clearing_in;
   logic [IW-1:0]                  clr_ff, clr_in;
   logic [lpsa_pkg::CASE_W-1:0]    rd_data_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   lpsa_pkg::rsp_type              rsp_ff, rsp_in;

   logic [EW-1:0]               cfg_ext;
   logic [CW-1:0]               eff_n_calc;
   logic [CW:0]                 rem_shift;
   logic [CW:0]                 rem_sub;
   logic [CW-1:0]               rem_next;
   logic [CW-1:0]               idx_plus;
   logic [CW-1:0]               tries_plus;
   logic [7:0]                  folded;
   logic [IW+lpsa_pkg::SLOT_OUT_W-1:0] slot_wide;
   logic [IW-1:0]               wr_addr;
   logic [lpsa_pkg::CASE_W-1:0] wr_data;
   logic                        wr_en;

   // effective slot count, clamped to 1..SLOTS
   always_comb begin
      cfg_ext = EW'(slots_cfg_ff);
      priority if (cfg_ext == '0) begin
         eff_n_calc = CW'(1);
      end else if (cfg_ext > SLOTS_EW) begin
         eff_n_calc = CW'(SLOTS);
      end else begin
         eff_n_calc = cfg_ext[CW-1:0];
      end
   end

   // one restoring remainder step per cycle, msb of the random value first
   always_comb begin
      rem_shift = {rem_ff, div_ff[lpsa_pkg::RND_W-1]};
      rem_sub   = rem_shift - {1'b0, eff_n_ff};
      if (rem_shift >= {1'b0, eff_n_ff}) begin
         rem_next = rem_sub[CW-1:0];
      end else begin
         rem_next = rem_shift[CW-1:0];
      end
   end

   assign idx_plus   = CW'(idx_ff) + CW'(1);
   assign tries_plus = tries_ff + CW'(1);

   always_comb begin
      if ((item_ff.status_byte >= lpsa_pkg::CHAR_UP_A) &&
          (item_ff.status_byte <= lpsa_pkg::CHAR_UP_Z)) begin
         folded = item_ff.status_byte + lpsa_pkg::CASE_BIT;
      end else begin
         folded = item_ff.status_byte;
      end
   end

   always_comb begin
      status.clearing  = clearing_ff;
      status.is_close  = (folded == lpsa_pkg::CHAR_C);
      status.is_open   = (folded == lpsa_pkg::CHAR_A);
      status.has_room  = (EW'(assigned_ff) < EW'(eff_n_ff));
      status.div_last  = (div_cnt_ff == '0);
      status.slot_free = (rd_data_ff == '0);
      status.last_try  = (tries_plus == eff_n_ff);
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign slot_wide = {{lpsa_pkg::SLOT_OUT_W{1'b0}}, idx_ff};

   always_comb begin
      slots_cfg_in = slots_cfg_ff;
      item_in      = item_ff;
      eff_n_in     = eff_n_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      div_cnt_in   = div_cnt_ff;
      idx_in       = idx_ff;
      tries_in     = tries_ff;
      assigned_in  = assigned_ff;
      clearing_in  = clearing_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr_write_enable) begin
         slots_cfg_in = csr_write_data;
      end
      if (clearing_ff) begin
         clr_in = clr_ff + IW'(1);
         if (clr_ff == LAST_SLOT) begin
            clearing_in = 1'b0;
         end
      end
      if (cmd.load) begin
         item_in    = req_payload;
         eff_n_in   = eff_n_calc;
         rem_in     = '0;
         div_in     = req_payload.random_value;
         div_cnt_in = '1;
      end
      if (cmd.div_step) begin
         rem_in     = rem_next;
         div_in     = {div_ff[lpsa_pkg::RND_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff - lpsa_pkg::RND_CNT_W'(1);
         if (div_cnt_ff == '0) begin
            idx_in   = rem_next[IW-1:0];
            tries_in = '0;
         end
      end
      if (cmd.advance) begin
         tries_in = tries_plus;
         if (idx_plus == eff_n_ff) begin
            idx_in = '0;
         end else begin
            idx_in = idx_plus[IW-1:0];
         end
      end
      if (cmd.mem_write) begin
         assigned_in = assigned_ff + lpsa_pkg::CSR_W'(1);
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.outcome     = cmd.outcome;
         rsp_in.echoed_case = item_ff.case_number;
         if (cmd.outcome == lpsa_pkg::OUT_ASSIGNED) begin
            rsp_in.slot_index = slot_wide[lpsa_pkg::SLOT_OUT_W-1:0];
         end else begin
            rsp_in.slot_index = '0;
         end
      end
   end

   // single write port shared by the clearing pass and slot assignment
   assign wr_en   = clearing_ff || cmd.mem_write;
   assign wr_addr = clearing_ff ? clr_ff : idx_ff;
   assign wr_data = clearing_ff ? '0 : item_ff.case_number;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_cfg_ff <= lpsa_pkg::CSR_RESET;
         assigned_ff  <= '0;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_cfg_ff <= slots_cfg_in;
         assigned_ff  <= assigned_in;
         clearing_ff  <= clearing_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff    <= item_in;
      eff_n_ff   <= eff_n_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      div_cnt_ff <= div_cnt_in;
      idx_ff     <= idx_in;
      tries_ff   <= tries_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> (CW'(idx_ff) < eff_n_ff))
      else $error("slot write outside the slots in use");

   a_no_load_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !cmd.load && !cmd.mem_write && !cmd.mem_read)
      else $error("table access during clearing pass");

   a_count_follows_write: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |=> (assigned_ff == lpsa_pkg::CSR_W'($past(assigned_ff) + 1'b1)))
      else $error("assigned count missed a slot write");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten before it was taken");
`endif

endmodule

@@ rtl/core/linear_probe_slot_assigner_unit.sv @@
// path per outcome: closed, unknown or table full go from the classify step straight to the result;
// assigned runs the start-slot divide, then probes past k occupied slots to a free one;
// pending after a fruitless probe of all n slots in use
// the start slot comes from a bit-serial remainder of the 16-bit random value, each probe is a read then a check
// one item at a time; the next beat is taken in the cycle after the result is queued
// reset: after reset is released, the table is cleared slot by slot before the first beat is taken
module linear_probe_slot_assigner_unit #(
   parameter int SLOTS = lpsa_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lpsa_pkg::req_type          req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lpsa_pkg::rsp_type          rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [lpsa_pkg::CSR_W-1:0] csr_write_data
);

   lpsa_pkg::cmd_type    cmd;
   lpsa_pkg::status_type status;

   lpsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lpsa_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule

@@ bench/tb_linear_probe_slot_assigner_unit.sv @@
// tb_linear_probe_slot_assigner_unit: self-checking bench for the slot assigner,
// with random request gaps, random response stalls and an in-bench slot table predictor
// depends on lpsa_pkg and linear_probe_slot_assigner_unit
module tb_linear_probe_slot_assigner_unit;

   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES    = 50;

   logic                       clock;
   logic                       reset;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   lpsa_pkg::req_type          req_payload      = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   lpsa_pkg::rsp_type          rsp_payload;
   logic                       csr_write_enable = 1'b0;
   logic [lpsa_pkg::CSR_W-1:0] csr_write_data   = '0;

   // predictor state
   logic [lpsa_pkg::CASE_W-1:0] slot_copy [lpsa_pkg::SLOTS_DEFAULT];
   logic [lpsa_pkg::CSR_W-1:0]  filled_slots  = '0;
   logic [lpsa_pkg::CSR_W-1:0]  slots_setting = lpsa_pkg::CSR_RESET;

   lpsa_pkg::req_type waiting_cases [$];
   lpsa_pkg::rsp_type predicted_replies [$];
   int unsigned       cases_queued    = 0;
   int unsigned       cases_offered   = 0;
   int unsigned       cases_taken     = 0;
   int unsigned       mismatch_count  = 0;
   int unsigned       send_gap        = 0;
   int unsigned       stall_left      = 0;
   int unsigned       hold_left       = 0;
   int unsigned       holds_requested = 0;
   int unsigned       holds_served    = 0;
   bit                steady_flow     = 1'b0;

   linear_probe_slot_assigner_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // classify one case and, for an open one, probe and fill the table copy
   function automatic lpsa_pkg::rsp_type assign_case(input lpsa_pkg::req_type item);
      lpsa_pkg::rsp_type reply;
      logic [7:0]        folded;
      int unsigned       span;
      int unsigned       probe;
      int unsigned       tries;
      bit                placed;
      reply             = '0;
      reply.echoed_case = item.case_number;
      folded            = item.status_byte;
      placed            = 1'b0;
      if (folded >= lpsa_pkg::CHAR_UP_A && folded <= lpsa_pkg::CHAR_UP_Z)
         folded = folded + lpsa_pkg::CASE_BIT;
      if (folded == lpsa_pkg::CHAR_C) begin
         reply.outcome = lpsa_pkg::OUT_CLOSED;
      end else if (folded == lpsa_pkg::CHAR_A) begin
         reply.outcome = lpsa_pkg::OUT_PENDING;
         span = 32'(slots_setting);
         if (span == 0) span = 1;
         if (span > lpsa_pkg::SLOTS_DEFAULT) span = lpsa_pkg::SLOTS_DEFAULT;
         if (filled_slots < span) begin
            probe = item.random_value % span;
            for (tries = 0; tries < span && !placed; tries++) begin
               if (slot_copy[probe] == '0) begin
                  slot_copy[probe] = item.case_number;
                  filled_slots     = filled_slots + lpsa_pkg::CSR_W'(1);
                  reply.outcome    = lpsa_pkg::OUT_ASSIGNED;
                  reply.slot_index = probe[lpsa_pkg::SLOT_OUT_W-1:0];
                  placed           = 1'b1;
               end else if (probe + 1 == span) begin
                  probe = 0;
               end else begin
                  probe = probe + 1;
               end
            end
         end
      end else begin
         reply.outcome = lpsa_pkg::OUT_UNKNOWN;
      end
      return reply;
   endfunction

   function automatic lpsa_pkg::req_type make_case(
         input logic [lpsa_pkg::CASE_W-1:0] number,
         input logic [7:0] status,
         input logic [lpsa_pkg::RND_W-1:0] start);
      lpsa_pkg::req_type item;
      item.case_number  = number;
      item.status_byte  = status;
      item.random_value = start;
      return item;
   endfunction

   function automatic lpsa_pkg::req_type random_case();
      lpsa_pkg::req_type item;
      int unsigned       roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)      item.status_byte = lpsa_pkg::CHAR_A;
      else if (roll < 60) item.status_byte = lpsa_pkg::CHAR_A ^ lpsa_pkg::CASE_BIT;
      else if (roll < 70) item.status_byte = lpsa_pkg::CHAR_C;
      else if (roll < 78) item.status_byte = lpsa_pkg::CHAR_C ^ lpsa_pkg::CASE_BIT;
      else                item.status_byte = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 5)       item.case_number = '0;
      else if (roll < 10) item.case_number = '1;
      else                item.case_number = lpsa_pkg::CASE_W'($urandom);
      item.random_value = lpsa_pkg::RND_W'($urandom_range(0, 65535));
      return item;
   endfunction

   task automatic queue_case(input lpsa_pkg::req_type item);
      waiting_cases.push_back(item);
      cases_queued++;
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", what);
   endtask

   task automatic check_reply(input lpsa_pkg::rsp_type seen);
      lpsa_pkg::rsp_type want;
      if (predicted_replies.size() == 0) begin
         report_mismatch($sformatf("reply with none outstanding: outcome %0d slot %0d case %0d",
                                   seen.outcome, seen.slot_index, seen.echoed_case));
      end else begin
         want = predicted_replies.pop_front();
         if (seen.outcome !== want.outcome)
            report_mismatch($sformatf("case %0d outcome: expected %0d, got %0d",
                                      want.echoed_case, want.outcome, seen.outcome));
         if (seen.slot_index !== want.slot_index)
            report_mismatch($sformatf("case %0d slot: expected %0d, got %0d",
                                      want.echoed_case, want.slot_index, seen.slot_index));
         if (seen.echoed_case !== want.echoed_case)
            report_mismatch($sformatf("echoed case: expected %0d, got %0d",
                                      want.echoed_case, seen.echoed_case));
      end
   endtask

   task automatic wait_until_drained();
      while (!(cases_taken == cases_queued && predicted_replies.size() == 0))
         @(negedge clock);
   endtask

   // the register is only rewritten with nothing in flight
   task automatic run_phase(input logic [lpsa_pkg::CSR_W-1:0] setting,
                            input int unsigned items,
                            input bit steady, input bit long_hold);
      wait_until_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      slots_setting     = setting;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      steady_flow       = steady;
      repeat (items) queue_case(random_case());
      if (long_hold) holds_requested++;
   endtask

   // request side
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && cases_taken != cases_offered) begin
         // stalled beat stays put
      end else if (send_gap > 0) begin
         send_gap  <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (waiting_cases.size() > 0) begin
         req_payload   <= waiting_cases.pop_front();
         req_valid     <= 1'b1;
         cases_offered <= cases_offered + 1;
         send_gap      <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response side stall, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holds_served != holds_requested) begin
         holds_served <= holds_requested;
         hold_left    <= LONG_HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predicted_replies.push_back(assign_case(req_payload));
         cases_taken++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_reply(rsp_payload);
   end

   initial begin
      for (int i = 0; i < lpsa_pkg::SLOTS_DEFAULT; i++) slot_copy[i] = '0;
      reset = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // full table span: closed, wraparound, zero case number, unknown codes
      queue_case(make_case(31'd1, lpsa_pkg::CHAR_C, 16'd0));
      queue_case(make_case('1, lpsa_pkg::CHAR_C ^ lpsa_pkg::CASE_BIT, 16'hFFFF));
      queue_case(make_case('1, lpsa_pkg::CHAR_A, 16'hFFFF));
      queue_case(make_case('0, lpsa_pkg::CHAR_A ^ lpsa_pkg::CASE_BIT, 16'hFFFF));
      queue_case(make_case(31'd1234, lpsa_pkg::CHAR_A, 16'd0));
      queue_case(make_case(31'd2, lpsa_pkg::CHAR_A, 16'd1024));
      queue_case(make_case(31'd3, 8'h00, 16'd7));
      queue_case(make_case(31'd4, 8'hFF, 16'd7));
      queue_case(make_case(31'd5, lpsa_pkg::CHAR_A + 8'd1, 16'd7));
      queue_case(make_case(31'd6, lpsa_pkg::CHAR_UP_A - 8'd1, 16'd7));
      queue_case(make_case(31'd7, lpsa_pkg::CHAR_UP_Z + 8'd1, 16'd7));
      queue_case(make_case(31'd8, lpsa_pkg::CHAR_UP_Z, 16'd7));
      queue_case(make_case(31'd9, lpsa_pkg::CHAR_A | 8'h80, 16'd7));
      queue_case(make_case(31'd10, lpsa_pkg::CHAR_C | 8'h80, 16'd7));
      queue_case(make_case(31'd11, (lpsa_pkg::CHAR_C ^ lpsa_pkg::CASE_BIT) | 8'h80, 16'd7));
      queue_case(make_case(31'h2AAAAAAA, lpsa_pkg::CHAR_A, 16'hAAAA));
      queue_case(make_case(31'h55555555, lpsa_pkg::CHAR_A, 16'h5555));

      // the slot count changes from phase to phase, from 0 and 1 up to the out-of-range 2047
      run_phase(11'd0,    20,  1'b0, 1'b0);
      run_phase(11'd8,    30,  1'b0, 1'b0);
      run_phase(11'd1,    20,  1'b0, 1'b0);
      run_phase(11'd16,   60,  1'b1, 1'b0);
      run_phase(11'd100,  250, 1'b0, 1'b1);
      run_phase(11'd2047, 200, 1'b0, 1'b0);
      run_phase(11'd300,  60,  1'b1, 1'b0);
      run_phase(11'd1024, 60,  1'b0, 1'b0);
      run_phase(11'd9,    30,  1'b1, 1'b0);

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // a probe walks at most 1024 slots, so this timeout is ample
   initial begin
      #400_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
